// File: hdl/tlzw_pkg.sv
// Shared constants and types for the TIFF LZW encoder.
// No dependencies; imported by tiff_lzw_encoder.
`timescale 1ns / 1ps

package tlzw_pkg;

    localparam logic [11:0] LZW_CLEAR      = 12'd256;
    localparam logic [11:0] LZW_EOI        = 12'd257;
    localparam logic [12:0] LZW_FIRST_FREE = 13'd258;
    localparam logic [12:0] CODE_LIMIT     = 13'd4094;
    localparam logic [3:0]  WIDTH_MIN      = 4'd9;
    localparam logic [3:0]  WIDTH_MAX      = 4'd12;
    localparam int          HASH_SHIFT     = 13 - 8;
    localparam logic [31:0] RATIO_BIG_IN   = 32'h007f_ffff;
    localparam logic [31:0] RATIO_MAX      = 32'h7fff_ffff;
    localparam logic [19:0] CHECK_RESET    = 20'd10000;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0_0000_0000_0001,
        S_LOOK  = 13'b0_0000_0000_0010,
        S_CMP   = 13'b0_0000_0000_0100,
        S_INS   = 13'b0_0000_0000_1000,
        S_UPD   = 13'b0_0000_0001_0000,
        S_DIV   = 13'b0_0000_0010_0000,
        S_RAT   = 13'b0_0000_0100_0000,
        S_FIN   = 13'b0_0000_1000_0000,
        S_FL1   = 13'b0_0001_0000_0000,
        S_FL2   = 13'b0_0010_0000_0000,
        S_PAD   = 13'b0_0100_0000_0000,
        S_SWEEP = 13'b0_1000_0000_0000,
        S_EMIT  = 13'b1_0000_0000_0000
    } t_state;

endpackage

// File: hdl/tiff_lzw_encoder.sv
// TIFF LZW encoder (9- to 12-bit codes, MSB-first packing) with hashed dictionary.
// Depends on tlzw_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] in_byte, tlast strip_end
//  m_axis    out        tdata[7:0] out_byte, tlast last_out
//  cfg       in         wdata[19:0] check_interval, written when we is high
//
// An input beat passes S_LOOK and S_CMP for each probe of the single-ported dictionary
// memory; a hit then goes to S_FIN, while a miss goes through S_INS, the byte packer
// in S_EMIT, which sends each output byte, and S_UPD. A ratio check runs the
// bit-serial divider in S_DIV over the 32 quotient bits. A table clear and the end of
// a strip add a clearing pass over all TABLE_SLOTS slots, which also runs after reset.
// Reset is synchronous, active low. A stalled output holds the sequencer.

module tiff_lzw_encoder
    import tlzw_pkg::*;
#(
    parameter int TABLE_SLOTS = 9001
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_wdata
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int PW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SLOTS - 1);
    localparam logic [IW:0]   SLOTS_X   = (IW+1)'(TABLE_SLOTS);
    localparam logic [PW-1:0] PROBE_MAX = PW'(TABLE_SLOTS);

    // Entry layout: {used, key[19:0], code[11:0]}
    logic [32:0] mem [TABLE_SLOTS];
    logic [32:0] r_rd;
    logic        mem_we;
    logic [32:0] mem_wd;

    t_state       r_state, n_state, r_ret, n_ret;
    logic [19:0]  r_ci;
    logic [7:0]   r_c, n_c;
    logic         r_last, n_last;
    logic [11:0]  r_prefix, n_prefix;
    logic         r_started, n_started;
    logic [12:0]  r_nfc, n_nfc;
    logic [3:0]   r_cw, n_cw;
    logic [6:0]   r_bbuf, n_bbuf;
    logic [2:0]   r_bcnt, n_bcnt;
    logic [31:0]  r_bytes, n_bytes;
    logic [31:0]  r_bits, n_bits;
    logic [31:0]  r_ncheck, n_ncheck;
    logic [31:0]  r_best, n_best;
    logic [IW-1:0] r_h, n_h;
    logic [IW-1:0] r_disp, n_disp;
    logic [PW-1:0] r_probes, n_probes;
    logic         r_free, n_free;
    logic         r_nclr, n_nclr;
    logic [18:0]  r_acc, n_acc;
    logic [4:0]   r_n, n_n;
    logic         r_final, n_final;
    logic [32:0]  r_rem, n_rem;
    logic [31:0]  r_quo, n_quo;
    logic [31:0]  r_div, n_div;
    logic [4:0]   r_dcnt, n_dcnt;
    logic         r_ovalid;
    logic [7:0]   r_obyte;
    logic         r_olast;

    // Emit request toward the byte packer.
    logic         e_go, e_final, e_bits_rst;
    logic [11:0]  e_code;
    t_state       e_ret;

    logic         push, push_last, space;
    logic [7:0]   push_byte;

    logic [19:0]  key;
    logic [IW-1:0] d_sel, h_dec;
    logic [IW:0]  h_sub;
    logic [32:0]  dv_t;
    logic [31:0]  dvd, dvs;
    logic [4:0]   n_sh;
    logic [14:0]  pad_w;
    logic [12:0]  cw_mask;

    assign space = !r_ovalid || i_m_axis_tready;
    assign key   = {r_c, r_prefix};
    assign cw_mask = (13'd1 << r_cw) - 13'd1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_obyte;
    assign o_m_axis_tlast  = r_olast;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_h] <= mem_wd;
        end
        r_rd <= mem[r_h];
    end

    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_c = r_c;         n_last = r_last;
        n_prefix = r_prefix; n_started = r_started; n_nfc = r_nfc;   n_cw = r_cw;
        n_bbuf = r_bbuf;     n_bcnt = r_bcnt;     n_bytes = r_bytes; n_bits = r_bits;
        n_ncheck = r_ncheck; n_best = r_best;     n_h = r_h;         n_disp = r_disp;
        n_probes = r_probes; n_free = r_free;     n_nclr = r_nclr;   n_acc = r_acc;
        n_n = r_n;           n_final = r_final;   n_rem = r_rem;     n_quo = r_quo;
        n_div = r_div;       n_dcnt = r_dcnt;
        e_go = 1'b0; e_final = 1'b0; e_bits_rst = 1'b0; e_code = r_prefix; e_ret = S_FIN;
        push = 1'b0; push_last = 1'b0; push_byte = '0;
        mem_we = 1'b0; mem_wd = '0;
        d_sel = '0; h_dec = '0; h_sub = '0; dv_t = '0; dvd = '0; dvs = '0;
        n_sh = '0; pad_w = '0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_c     = i_s_axis_tdata;
                    n_last  = i_s_axis_tlast;
                    n_bytes = r_bytes + 32'd1;
                    if (!r_started) begin
                        e_go      = 1'b1;
                        e_code    = LZW_CLEAR;
                        e_ret     = S_FIN;
                        n_prefix  = {4'd0, i_s_axis_tdata};
                        n_started = 1'b1;
                    end else begin
                        // The xor of a 13-bit shifted byte and a 12-bit code never
                        // reaches the table size, so no reduction is needed.
                        n_h = IW'(({5'd0, i_s_axis_tdata} << HASH_SHIFT)
                                  ^ {1'b0, r_prefix});
                        n_probes = '0;
                        n_state  = S_LOOK;
                    end
                end
            end
            S_LOOK: n_state = S_CMP;
            S_CMP: begin
                if (r_rd[32] && r_rd[31:12] == key) begin
                    n_prefix = r_rd[11:0];
                    n_state  = S_FIN;
                end else if (!r_rd[32]) begin
                    n_free  = 1'b1;
                    n_state = S_INS;
                end else if (r_probes == PROBE_MAX) begin
                    n_free  = 1'b0;
                    n_state = S_INS;
                end else begin
                    if (r_probes == '0) begin
                        d_sel = (r_h == '0) ? IW'(1) : IW'(SLOTS_X - {1'b0, r_h});
                    end else begin
                        d_sel = r_disp;
                    end
                    n_disp = d_sel;
                    h_sub  = {1'b0, r_h} - {1'b0, d_sel};
                    h_dec  = h_sub[IW] ? IW'(h_sub + SLOTS_X) : h_sub[IW-1:0];
                    n_h    = h_dec;
                    n_probes = r_probes + PW'(1);
                    n_state  = S_LOOK;
                end
            end
            S_INS: begin
                e_go     = 1'b1;
                e_code   = r_prefix;
                e_ret    = S_UPD;
                n_prefix = {4'd0, r_c};
                mem_we   = r_free;
                mem_wd   = {1'b1, key, r_nfc[11:0]};
                n_nfc    = r_nfc + 13'd1;
            end
            S_UPD: begin
                if (r_nfc == CODE_LIMIT) begin
                    n_best   = '0;
                    n_bytes  = '0;
                    n_nfc    = LZW_FIRST_FREE;
                    e_go     = 1'b1;
                    e_code   = LZW_CLEAR;
                    e_ret    = S_FIN;
                    e_bits_rst = 1'b1;
                    n_cw     = WIDTH_MIN;
                    n_nclr   = 1'b1;
                end else if (r_nfc > cw_mask) begin
                    if (r_cw < WIDTH_MAX) begin
                        n_cw = r_cw + 4'd1;
                    end
                    n_state = S_FIN;
                end else if (r_bytes >= r_ncheck) begin
                    n_ncheck = r_bytes + {12'd0, r_ci};
                    if (r_bytes > RATIO_BIG_IN) begin
                        dvd = r_bytes;
                        dvs = {8'd0, r_bits[31:8]};
                    end else begin
                        dvd = {r_bytes[23:0], 8'd0};
                        dvs = r_bits;
                    end
                    if (dvs == '0) begin
                        n_quo   = RATIO_MAX;
                        n_state = S_RAT;
                    end else begin
                        n_quo   = dvd;
                        n_rem   = '0;
                        n_div   = dvs;
                        n_dcnt  = '0;
                        n_state = S_DIV;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                dv_t = {r_rem[31:0], r_quo[31]};
                if (dv_t >= {1'b0, r_div}) begin
                    n_rem = dv_t - {1'b0, r_div};
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = dv_t;
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = S_RAT;
                end
            end
            S_RAT: begin
                if (r_quo <= r_best) begin
                    n_best   = '0;
                    n_bytes  = '0;
                    n_nfc    = LZW_FIRST_FREE;
                    e_go     = 1'b1;
                    e_code   = LZW_CLEAR;
                    e_ret    = S_FIN;
                    e_bits_rst = 1'b1;
                    n_cw     = WIDTH_MIN;
                    n_nclr   = 1'b1;
                end else begin
                    n_best  = r_quo;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_last) begin
                    e_go   = 1'b1;
                    e_code = r_prefix;
                    e_ret  = S_FL1;
                end else if (r_nclr) begin
                    n_h     = '0;
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FL1: begin
                n_nfc = r_nfc + 13'd1;
                if (r_nfc + 13'd1 == CODE_LIMIT) begin
                    e_go   = 1'b1;
                    e_code = LZW_CLEAR;
                    e_ret  = S_FL2;
                    n_cw   = WIDTH_MIN;
                end else begin
                    if (r_nfc + 13'd1 > cw_mask && r_cw < WIDTH_MAX) begin
                        n_cw = r_cw + 4'd1;
                    end
                    n_state = S_FL2;
                end
            end
            S_FL2: begin
                e_go    = 1'b1;
                e_code  = LZW_EOI;
                e_final = 1'b1;
                e_ret   = S_PAD;
            end
            S_PAD: begin
                pad_w     = {8'd0, r_bbuf} << (4'd8 - {1'b0, r_bcnt});
                push_byte = pad_w[7:0];
                push_last = 1'b1;
                if (r_bcnt == '0 || space) begin
                    push      = (r_bcnt != '0);
                    n_prefix  = '0;
                    n_started = 1'b0;
                    n_nfc     = LZW_FIRST_FREE;
                    n_cw      = WIDTH_MIN;
                    n_bbuf    = '0;
                    n_bcnt    = '0;
                    n_bytes   = '0;
                    n_bits    = '0;
                    n_ncheck  = {12'd0, r_ci};
                    n_best    = '0;
                    n_h       = '0;
                    n_state   = S_SWEEP;
                end
            end
            S_SWEEP: begin
                mem_we = 1'b1;
                mem_wd = '0;
                n_h    = r_h + IW'(1);
                if (r_h == LAST_SLOT) begin
                    n_nclr  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (r_n >= 5'd8) begin
                    n_sh      = r_n - 5'd8;
                    push_byte = 8'(r_acc >> n_sh);
                    push_last = r_final && (n_sh == '0);
                    if (space) begin
                        push = 1'b1;
                        n_n  = n_sh;
                    end
                end else begin
                    n_bbuf  = r_acc[6:0] & ((7'd1 << r_n[2:0]) - 7'd1);
                    n_bcnt  = r_n[2:0];
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Start of a code emission: the code is appended below the pending bits.
        if (e_go) begin
            n_acc   = ({12'd0, r_bbuf} << r_cw) | {7'd0, e_code};
            n_n     = {2'd0, r_bcnt} + {1'b0, r_cw};
            n_bits  = e_bits_rst ? {28'd0, r_cw} : r_bits + {28'd0, r_cw};
            n_final = e_final;
            n_ret   = e_ret;
            n_state = S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_ret     <= S_IDLE;
            r_ci      <= CHECK_RESET;
            r_prefix  <= '0;
            r_started <= 1'b0;
            r_nfc     <= LZW_FIRST_FREE;
            r_cw      <= WIDTH_MIN;
            r_bbuf    <= '0;
            r_bcnt    <= '0;
            r_bytes   <= '0;
            r_bits    <= '0;
            r_ncheck  <= {12'd0, CHECK_RESET};
            r_best    <= '0;
            r_h       <= '0;
            r_probes  <= '0;
            r_nclr    <= 1'b0;
            r_n       <= '0;
            r_final   <= 1'b0;
            r_dcnt    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            if (i_cfg_we) begin
                r_ci <= i_cfg_wdata;
            end
            r_prefix  <= n_prefix;
            r_started <= n_started;
            r_nfc     <= n_nfc;
            r_cw      <= n_cw;
            r_bbuf    <= n_bbuf;
            r_bcnt    <= n_bcnt;
            r_bytes   <= n_bytes;
            r_bits    <= n_bits;
            r_ncheck  <= n_ncheck;
            r_best    <= n_best;
            r_h       <= n_h;
            r_probes  <= n_probes;
            r_nclr    <= n_nclr;
            r_n       <= n_n;
            r_final   <= n_final;
            r_dcnt    <= n_dcnt;
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_last <= n_last;
        r_disp <= n_disp;
        r_free <= n_free;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_div  <= n_div;
        if (push) begin
            r_obyte <= push_byte;
            r_olast <= push_last;
        end
    end

endmodule

// File: verif/tb_top.sv
// Self-checking bench for tiff_lzw_encoder: stream in raw strip bytes, predict the LZW bytes.
// Depends on tlzw_pkg and tiff_lzw_encoder; the predictor below is independent of the RTL.
`timescale 1ns / 1ps

module tb_top;
    import tlzw_pkg::*;

    localparam int SLOTS      = 9001;
    localparam int SWEEP_WAIT = 9400;

    typedef enum logic [1:0] {K_BYTE, K_DRAIN, K_CFG} t_kind;
    typedef struct {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic [19:0] cfg;
    } t_stim;
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_obyte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'd0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [19:0] cfg_data = 20'd0;
    logic        s_ready, m_valid, m_last;
    logic [7:0]  m_data;

    tiff_lzw_encoder #(.TABLE_SLOTS(SLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tlast(m_last),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_stim  pending_q[$];
    t_obyte lzw_bytes_q[$];
    int     n_errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Encoder shadow state.
    bit [19:0]   d_key[SLOTS];
    bit [11:0]   d_code[SLOTS];
    bit          d_used[SLOTS];
    int unsigned prefix, next_code, width, bbuf, bcnt;
    int unsigned n_bytes, n_bits, check_at, best, interval;
    bit          started;
    t_obyte      step_q[$];

    function automatic void put_byte(int unsigned b);
        t_obyte o;
        if (step_q.size() < 9) begin
            o.data = b[7:0];
            o.last = 1'b0;
            step_q.push_back(o);
        end
    endfunction

    function automatic void pack_code(int unsigned code);
        int unsigned acc, n;
        acc = (bbuf << width) | (code & 32'hfff);
        n = bcnt + width;
        while (n >= 8) begin
            n -= 8;
            put_byte(acc >> n);
        end
        bbuf = acc & ((32'd1 << n) - 1);
        bcnt = n;
        n_bits += width;
    endfunction

    function automatic void clear_dict();
        foreach (d_used[i]) d_used[i] = 1'b0;
    endfunction

    function automatic void table_restart();
        clear_dict();
        best = 0;
        n_bytes = 0;
        n_bits = 0;
        next_code = 32'(LZW_FIRST_FREE);
        pack_code(32'(LZW_CLEAR));
        width = 32'(WIDTH_MIN);
    endfunction

    function automatic void strip_restart();
        clear_dict();
        prefix = 0;
        started = 1'b0;
        next_code = 32'(LZW_FIRST_FREE);
        width = 32'(WIDTH_MIN);
        bbuf = 0;
        bcnt = 0;
        n_bytes = 0;
        n_bits = 0;
        check_at = interval;
        best = 0;
    endfunction

    function automatic int unsigned ratio();
        int unsigned d;
        if (n_bytes > RATIO_BIG_IN) begin
            d = n_bits >> 8;
            return (d == 0) ? RATIO_MAX : n_bytes / d;
        end
        if (n_bits == 0) return RATIO_MAX;
        return (n_bytes << 8) / n_bits;
    endfunction

    function automatic void add_byte(int unsigned c);
        int unsigned key, r;
        int h, disp, p;
        bit free_slot;
        key = (c << 12) + prefix;
        h = int'(((c << HASH_SHIFT) ^ prefix) % SLOTS);
        free_slot = 1'b0;
        n_bytes++;
        if (d_used[h] && d_key[h] == key) begin
            prefix = 32'(d_code[h]);
            return;
        end
        if (!d_used[h]) begin
            free_slot = 1'b1;
        end else begin
            disp = (h == 0) ? 1 : SLOTS - h;
            for (p = 0; p < SLOTS; p++) begin
                h -= disp;
                if (h < 0) h += SLOTS;
                if (!d_used[h]) begin
                    free_slot = 1'b1;
                    break;
                end
                if (d_key[h] == key) begin
                    prefix = 32'(d_code[h]);
                    return;
                end
            end
        end
        pack_code(prefix);
        prefix = c;
        if (free_slot) begin
            d_used[h] = 1'b1;
            d_key[h]  = key[19:0];
            d_code[h] = next_code[11:0];
        end
        next_code++;
        if (next_code == CODE_LIMIT) begin
            table_restart();
        end else if (next_code > (32'd1 << width) - 1) begin
            if (width < WIDTH_MAX) width++;
        end else if (n_bytes >= check_at) begin
            check_at = n_bytes + interval;
            r = ratio();
            if (r <= best) table_restart();
            else best = r;
        end
    endfunction

    // Predicts the output bytes caused by one accepted input beat.
    function automatic void predict_beat(logic [7:0] c, logic last);
        step_q.delete();
        if (!started) begin
            pack_code(32'(LZW_CLEAR));
            prefix = 32'(c);
            n_bytes++;
            started = 1'b1;
        end else begin
            add_byte(32'(c));
        end
        if (last) begin
            pack_code(prefix);
            next_code++;
            if (next_code == CODE_LIMIT) begin
                pack_code(32'(LZW_CLEAR));
                width = 32'(WIDTH_MIN);
            end else if (next_code > (32'd1 << width) - 1) begin
                if (width < WIDTH_MAX) width++;
            end
            pack_code(32'(LZW_EOI));
            if (bcnt > 0) put_byte(bbuf << (8 - bcnt));
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
            strip_restart();
        end
        foreach (step_q[i]) lzw_bytes_q.push_back(step_q[i]);
    endfunction

    // Monitor: prediction on accepted input beats, comparison on output beats.
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    always @(posedge i_clk) begin
        t_obyte e;
        s_taken <= s_valid && s_ready;
        m_taken <= m_valid && m_ready;
        if (i_rst_n && s_valid && s_ready) predict_beat(s_data, s_last);
        if (i_rst_n && m_valid && m_ready) begin
            if (lzw_bytes_q.size() == 0) begin
                report($sformatf("unexpected beat data=%02h last=%b", m_data, m_last));
            end else begin
                e = lzw_bytes_q.pop_front();
                if (m_data !== e.data)
                    report($sformatf("data %02h, expected %02h", m_data, e.data));
                if (m_last !== e.last)
                    report($sformatf("last %b, expected %b", m_last, e.last));
            end
        end
    end

    // Driver: input beats from the pending queue, drain pauses and register writes.
    int drv_gap = 0;
    int drain_cnt = 0;
    int rx_stall = 0;
    bit calm = 1'b0;
    always @(negedge i_clk) begin
        t_stim st;
        logic nv;
        logic nwe;
        nv = s_valid;
        nwe = 1'b0;
        if (i_rst_n && (!s_valid || s_taken)) begin
            nv = 1'b0;
            if (drv_gap > 0) begin
                drv_gap--;
            end else if (pending_q.size() > 0) begin
                st = pending_q[0];
                case (st.kind)
                    K_BYTE: begin
                        void'(pending_q.pop_front());
                        s_data <= st.data;
                        s_last <= st.last;
                        nv = 1'b1;
                        if ($urandom_range(0, 39) == 0) calm = ~calm;
                        drv_gap = calm ? 0 : $urandom_range(0, 3);
                    end
                    K_DRAIN: begin
                        // Hold off until all output has come and the clearing pass is over.
                        if (lzw_bytes_q.size() != 0) begin
                            drain_cnt = 0;
                        end else if (++drain_cnt >= SWEEP_WAIT) begin
                            drain_cnt = 0;
                            void'(pending_q.pop_front());
                        end
                    end
                    default: begin
                        void'(pending_q.pop_front());
                        nwe = 1'b1;
                        cfg_data <= st.cfg;
                        interval = 32'(st.cfg);
                    end
                endcase
            end
        end
        s_valid <= nv;
        cfg_we <= nwe;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (m_taken || !m_ready) begin
            if (m_taken) rx_stall = calm ? 0 : $urandom_range(0, 3);
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_beat(input logic [7:0] d, input logic l);
        t_stim st;
        st.kind = K_BYTE;
        st.data = d;
        st.last = l;
        st.cfg = '0;
        pending_q.push_back(st);
    endtask

    task automatic add_control(input t_kind k, input logic [19:0] v);
        t_stim st;
        st.kind = k;
        st.data = '0;
        st.last = 1'b0;
        st.cfg = v;
        pending_q.push_back(st);
    endtask

    // Random strips; a narrow alphabet gives long dictionary hits, a wide one many new codes.
    task automatic add_strips(input int n_beats);
        int len, alpha, i;
        while (n_beats > 0) begin
            len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            if (len > n_beats) len = n_beats;
            alpha = ($urandom_range(0, 1) == 0) ? 3 : 255;
            for (i = 0; i < len; i++)
                add_beat(8'($urandom_range(0, alpha)), i == len - 1);
            n_beats -= len;
        end
    endtask

    initial begin
        int i;
        interval = 32'(CHECK_RESET);
        strip_restart();
        check_at = 32'(CHECK_RESET);
        // Single-byte strips at both byte extremes.
        add_beat(8'h00, 1'b1);
        add_beat(8'hff, 1'b1);
        // Repeated bytes build a chain of dictionary hits.
        for (i = 0; i < 10; i++) add_beat(8'haa, 1'b0);
        add_beat(8'h55, 1'b1);
        for (i = 0; i < 10; i++) add_beat(i[0] ? 8'hff : 8'h00, i == 9);
        add_strips(150);
        add_control(K_DRAIN, '0);
        add_control(K_CFG, 20'd1);
        add_strips(40);
        add_control(K_DRAIN, '0);
        add_control(K_CFG, 20'd1000000);
        add_strips(110);
        add_control(K_DRAIN, '0);
        add_control(K_CFG, 20'd7);
        add_strips(110);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0 || s_valid) @(posedge i_clk);
        while (lzw_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SWEEP_WAIT) @(posedge i_clk);
        if (n_errors == 0 && lzw_bytes_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
